>>> src/rrlh_pkg.sv
// types, constants and controller interface for the round-robin lock handoff core
`timescale 1ns / 1ps

package rrlh_pkg;

	localparam int MAX_THREADS = 64;
	localparam int TID_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = TID_W + 1;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_THREADS);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_THREADS);
	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(1);

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic KIND_IMMEDIATE = 1'b0;
	localparam logic KIND_HANDOFF   = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [TID_W-1:0] thread;
	} rrlh_in_t;

	typedef struct packed {
		logic [TID_W-1:0] granted_thread;
		logic             grant_kind;
	} rrlh_out_t;

	typedef struct packed {
		logic load;
		logic pick;
		logic commit;
	} rrlh_cmd_t;

	typedef struct packed {
		logic in_range;
	} rrlh_status_t;

endpackage

>>> src/rrlh_pick.sv
// lowest set bit finder over the waiting marks
`timescale 1ns / 1ps

module rrlh_pick
	import rrlh_pkg::*;
(
	input  logic [MAX_THREADS-1:0] mask,
	output logic                   found,
	output logic [TID_W-1:0]       index
);

	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				found = 1'b1;
				index = TID_W'(i);
			end
		end
	end

endmodule

>>> src/rrlh_ctrl.sv
// controller state machine: accept, pick, commit
`timescale 1ns / 1ps

module rrlh_ctrl
	import rrlh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  rrlh_status_t status,
	output rrlh_cmd_t    cmd,
	output logic         busy
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_PICK   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_PICK;
				end
			end
			ST_PICK: begin
				if (status.in_range) begin
					state_next = ST_COMMIT;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_COMMIT: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.pick   = (state_q == ST_PICK) && status.in_range;
	assign cmd.commit = (state_q == ST_COMMIT);

endmodule

>>> src/rrlh_dp.sv
// datapath: waiting marks, free token, round-robin search and result word
`timescale 1ns / 1ps

module rrlh_dp
	import rrlh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rrlh_cmd_t    cmd,
	output rrlh_status_t status,
	input  rrlh_in_t     req,
	input  logic         cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	output logic         result_valid,
	output rrlh_out_t    result
);

	rrlh_in_t               op_q;
	logic [CNT_W-1:0]       count_q;
	logic [MAX_THREADS-1:0] marks_q;
	logic                   free_q;
	logic                   found_s1;
	logic [TID_W-1:0]       cand_s1;
	logic                   result_valid_q;
	rrlh_out_t              result_q;

	logic [CNT_W-1:0]       eff_n;
	logic [MAX_THREADS-1:0] above_mask;
	logic [MAX_THREADS-1:0] below_mask;
	logic [MAX_THREADS-1:0] thread_bit;
	logic                   hi_found;
	logic                   lo_found;
	logic [TID_W-1:0]       hi_index;
	logic [TID_W-1:0]       lo_index;

	always_comb begin
		if (count_q < CNT_MIN) begin
			eff_n = CNT_MIN;
		end else if (count_q > CNT_MAX) begin
			eff_n = CNT_MAX;
		end else begin
			eff_n = count_q;
		end
	end

	assign status.in_range = ({1'b0, op_q.thread} < eff_n);
	assign thread_bit      = MAX_THREADS'(1) << op_q.thread;

	// successors up to the count, then wrap to those below the releaser
	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			above_mask[i] = marks_q[i] && (CNT_W'(i) > {1'b0, op_q.thread})
				&& (CNT_W'(i) < eff_n);
			below_mask[i] = marks_q[i] && (CNT_W'(i) < {1'b0, op_q.thread});
		end
	end

	rrlh_pick u_pick_hi (
		.mask  (above_mask),
		.found (hi_found),
		.index (hi_index)
	);

	rrlh_pick u_pick_lo (
		.mask  (below_mask),
		.found (lo_found),
		.index (lo_index)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req;
		end
		if (cmd.pick) begin
			found_s1 <= hi_found || lo_found;
			cand_s1  <= hi_found ? hi_index : lo_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= CNT_RESET;
			marks_q        <= '0;
			free_q         <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (op_q.cmd == CMD_ACQUIRE) begin
					marks_q <= marks_q | thread_bit;
					if (free_q) begin
						free_q         <= 1'b0;
						result_valid_q <= 1'b1;
					end
				end else begin
					marks_q <= marks_q & ~thread_bit;
					if (found_s1) begin
						result_valid_q <= 1'b1;
					end else begin
						free_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q.cmd == CMD_ACQUIRE) begin
				result_q.granted_thread <= op_q.thread;
				result_q.grant_kind     <= KIND_IMMEDIATE;
			end else begin
				result_q.granted_thread <= cand_s1;
				result_q.grant_kind     <= KIND_HANDOFF;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> src/round_robin_lock_handoff_core.sv
// top level of the round-robin lock handoff core
// a grant word, when one is given, is registered in the commit step, after the pick step
// the core takes no new command until the pick and commit steps of the controller
// are done; busy stays high while those steps run after start is taken
// an out-of-range thread id frees the core after the pick step, skips commit and gives no word
// reset: all waiting marks clear, lock free, thread count 64; no clearing pass
`timescale 1ns / 1ps

module round_robin_lock_handoff_core
	import rrlh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rrlh_in_t         req,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             result_valid,
	output rrlh_out_t        result
);

	rrlh_cmd_t    ctrl_cmd;
	rrlh_status_t dp_status;

	rrlh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (dp_status),
		.cmd    (ctrl_cmd),
		.busy   (busy)
	);

	rrlh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.status       (dp_status),
		.req          (req),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	assign cfg_ready = !busy;

	a_taken_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken but core not busy");

	a_word_after_command: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 3))
		else $error("grant word without a command three cycles earlier");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("two grant words in a row");

	a_immediate_to_requester: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.grant_kind == KIND_IMMEDIATE)
		|-> (result.granted_thread == $past(req.thread, 3)))
		else $error("immediate grant to a thread other than the requester");

endmodule
